// ===== sv/rac_pkg.sv =====
// ----------------------------------------------------------------------------
// rac_pkg
// Shared types, codes and helpers for the region adjacency counter.
// ----------------------------------------------------------------------------
package rac_pkg;

  localparam int unsigned RAC_MAX_COLUMNS = 4096;
  localparam int unsigned RAC_MAX_PAIRS   = 1024;

  localparam int unsigned LABEL_W = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned COLS_W  = 13;
  localparam int unsigned ENTRY_W = 2 * LABEL_W + COUNT_W;

  localparam logic [COLS_W-1:0] COLS_RESET = 13'd4096;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_FETCH = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [0:0] {
    REG_COLUMNS  = 1'b0,
    REG_DIAGONAL = 1'b1
  } reg_index_e;

  // Neighbour slots, in the order they are applied.
  typedef enum logic [1:0] {
    NB_TOP       = 2'd0,
    NB_LEFT      = 2'd1,
    NB_TOP_LEFT  = 2'd2,
    NB_TOP_RIGHT = 2'd3
  } nb_slot_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ROW   = 9'b000000010,
    S_NB    = 9'b000000100,
    S_SRCH  = 9'b000001000,
    S_CMP   = 9'b000010000,
    S_MATCH = 9'b000100000,
    S_SHRD  = 9'b001000000,
    S_SHWR  = 9'b010000000,
    S_FETCH = 9'b100000000
  } state_e;

  // Lexicographic signed order on (lower, higher).
  function automatic logic pair_less(input logic signed [LABEL_W-1:0] a_lo,
                                     input logic signed [LABEL_W-1:0] a_hi,
                                     input logic signed [LABEL_W-1:0] b_lo,
                                     input logic signed [LABEL_W-1:0] b_hi);
    return (a_lo < b_lo) || ((a_lo == b_lo) && (a_hi < b_hi));
  endfunction

endpackage

// ===== sv/region_adjacency_counter_unit.sv =====
// ----------------------------------------------------------------------------
// region_adjacency_counter_unit
// Builds a sorted table of adjacent label pairs from a streamed label raster.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one item per transfer:
// a pixel, a fetch of the next stored pair, or a clear. Only a fetch makes
// a result, which leaves on the output channel (out_valid_o/out_ready_i)
// from a single output register.
// A pixel that forms no pair passes the transfer (row store read), the row
// store write and the neighbour check. Each neighbour that forms a pair
// adds a set-up step, a binary search in the pair memory with a read and a
// compare per probe (up to log2(pairs stored)+1 probes) and a closing read,
// and a match check; a new pair then shifts the higher entries up by one
// place, each with a read and a write, and is then written. The pair memory
// sets the rate: a pixel costs most when four new pairs land low in a nearly
// full table. A fetch reads the pair memory at its transfer and registers
// its result once the output register is free; a clear or an unused opcode
// is done at its transfer.
// Input is taken while the output register still holds a result; a fetch
// waits in place until the register is free, so a stalled receiver stalls
// the next fetch and, while it waits, all input behind it.
// Reset (rst_ni low) empties the table and the raster position; row store
// and pair memory need no clearing pass since a fill mark tracks the valid
// part of the row store and a count the valid part of the table.
// ----------------------------------------------------------------------------
module region_adjacency_counter_unit
  import rac_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = RAC_MAX_COLUMNS,
  parameter int unsigned MAX_PAIRS   = RAC_MAX_PAIRS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [COLS_W-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                opcode_i,
  input  logic signed [LABEL_W-1:0] pixel_label_i,
  input  logic                      pixel_is_null_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [LABEL_W-1:0] lower_label_o,
  output logic signed [LABEL_W-1:0] higher_label_o,
  output logic [COUNT_W-1:0]        border_count_o,
  output logic                      pair_valid_o,
  output logic                      last_pair_o,
  output logic                      table_overflow_o
);

  localparam int unsigned CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned CCW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned PW  = $clog2(MAX_PAIRS);
  localparam int unsigned PCW = $clog2(MAX_PAIRS + 1);

  // Configuration
  logic [COLS_W-1:0] cols_q;
  logic              diag_q;
  logic [CCW-1:0]    eff_cols;

  // Raster state
  logic [CCW-1:0]            col_q, hwm_q, c_q;
  logic                      left_v_q, tl_v_q, cur_v_q;
  logic signed [LABEL_W-1:0] left_lab_q, tl_lab_q, cur_lab_q;

  // Row store: {valid, label}
  logic [LABEL_W:0] rs_mem [MAX_COLUMNS];
  logic [LABEL_W:0] rs_top_q, rs_tr_q;
  logic [CW-1:0]    rs_ra0, rs_ra1;
  logic             col_wrap;
  logic [CCW-1:0]   c_cur, cp1;

  // Pair memory: {lower, higher, count}
  logic [ENTRY_W-1:0] pm_mem [MAX_PAIRS];
  logic [ENTRY_W-1:0] pm_rdata_q, pm_wdata;
  logic [PW-1:0]      pm_raddr, pm_waddr;
  logic               pm_we;

  logic [PCW-1:0] stored_q, fetch_q, bs_lo_q, bs_hi_q, sh_q;
  logic [PCW:0]   bs_sum;
  logic [PCW-1:0] mid;
  logic           ovf_q;

  logic [3:0]                nb_v_q;
  logic signed [LABEL_W-1:0] nb_lab_q [4];
  logic signed [LABEL_W-1:0] key_lo_q, key_hi_q;

  logic signed [LABEL_W-1:0] e_lo, e_hi;
  logic [COUNT_W-1:0]        e_cnt;
  logic                      e_less, e_eq, full, out_free;

  state_e state_q;

  logic [1:0]                nb_sel;
  logic signed [LABEL_W-1:0] nb_lab;

  logic out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free = !out_valid_q || out_ready_i;

  // Clamp the row length into 1..MAX_COLUMNS
  always_comb begin
    if (cols_q == '0) begin
      eff_cols = CCW'(1);
    end else if (32'(cols_q) > MAX_COLUMNS) begin
      eff_cols = CCW'(MAX_COLUMNS);
    end else begin
      eff_cols = CCW'(cols_q);
    end
  end

  // A column beyond the current row length starts a new row
  assign col_wrap = (col_q >= eff_cols);
  assign c_cur    = col_wrap ? '0 : col_q;
  assign rs_ra0   = c_cur[CW-1:0];
  assign rs_ra1   = CW'(c_cur + CCW'(1));
  assign cp1      = c_q + CCW'(1);

  always_ff @(posedge clk_i) begin
    if (state_q == S_ROW) begin
      rs_mem[c_q[CW-1:0]] <= {cur_v_q, cur_lab_q};
    end
    rs_top_q <= rs_mem[rs_ra0];
    rs_tr_q  <= rs_mem[rs_ra1];
  end

  // Pair memory port
  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pm_mem[pm_waddr] <= pm_wdata;
    end
    pm_rdata_q <= pm_mem[pm_raddr];
  end

  assign e_lo   = pm_rdata_q[ENTRY_W-1 -: LABEL_W];
  assign e_hi   = pm_rdata_q[COUNT_W +: LABEL_W];
  assign e_cnt  = pm_rdata_q[COUNT_W-1:0];
  assign e_less = pair_less(e_lo, e_hi, key_lo_q, key_hi_q);
  assign e_eq   = (e_lo == key_lo_q) && (e_hi == key_hi_q);
  assign full   = (stored_q == PCW'(MAX_PAIRS));
  assign bs_sum = {1'b0, bs_lo_q} + {1'b0, bs_hi_q};
  assign mid    = bs_sum[PCW:1];

  // Lowest pending neighbour slot
  always_comb begin
    if (nb_v_q[NB_TOP]) begin
      nb_sel = NB_TOP;
    end else if (nb_v_q[NB_LEFT]) begin
      nb_sel = NB_LEFT;
    end else if (nb_v_q[NB_TOP_LEFT]) begin
      nb_sel = NB_TOP_LEFT;
    end else begin
      nb_sel = NB_TOP_RIGHT;
    end
  end
  assign nb_lab = nb_lab_q[nb_sel];

  // Memory port control
  always_comb begin
    pm_raddr = fetch_q[PW-1:0];
    pm_we    = 1'b0;
    pm_waddr = sh_q[PW-1:0];
    pm_wdata = pm_rdata_q;
    case (state_q)
      S_SRCH: begin
        if (bs_lo_q < bs_hi_q) begin
          pm_raddr = mid[PW-1:0];
        end else begin
          pm_raddr = bs_lo_q[PW-1:0];
        end
      end
      S_MATCH: begin
        pm_waddr = bs_lo_q[PW-1:0];
        if (bs_lo_q < stored_q && e_eq) begin
          pm_we    = 1'b1;
          pm_wdata = {e_lo, e_hi, (&e_cnt) ? e_cnt : e_cnt + COUNT_W'(1)};
        end
      end
      S_SHRD: begin
        pm_raddr = PW'(sh_q - PCW'(1));
        if (sh_q == bs_lo_q) begin
          pm_we    = 1'b1;
          pm_waddr = bs_lo_q[PW-1:0];
          pm_wdata = {key_lo_q, key_hi_q, COUNT_W'(1)};
        end
      end
      S_SHWR: begin
        pm_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cols_q      <= COLS_RESET;
      diag_q      <= 1'b0;
      col_q       <= '0;
      hwm_q       <= '0;
      c_q         <= '0;
      left_v_q    <= 1'b0;
      tl_v_q      <= 1'b0;
      cur_v_q     <= 1'b0;
      stored_q    <= '0;
      fetch_q     <= '0;
      ovf_q       <= 1'b0;
      nb_v_q      <= '0;
      bs_lo_q     <= '0;
      bs_hi_q     <= '0;
      sh_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_COLUMNS:  cols_q <= cfg_wdata_i;
          REG_DIAGONAL: diag_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end

      // A new fetch result replaces one taken at this same edge
      if (state_q == S_FETCH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (opcode_i)
              OP_PIXEL: begin
                c_q       <= c_cur;
                cur_v_q   <= !pixel_is_null_i;
                cur_lab_q <= pixel_is_null_i ? '0 : pixel_label_i;
                if (col_wrap) begin
                  left_v_q <= 1'b0;
                  tl_v_q   <= 1'b0;
                end
                state_q <= S_ROW;
              end
              OP_FETCH: state_q <= S_FETCH;
              OP_CLEAR: begin
                col_q    <= '0;
                hwm_q    <= '0;
                left_v_q <= 1'b0;
                tl_v_q   <= 1'b0;
                stored_q <= '0;
                fetch_q  <= '0;
                ovf_q    <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end

        S_ROW: begin
          // Neighbours that form a pair with the current pixel
          nb_v_q[NB_TOP]  <= cur_v_q && rs_top_q[LABEL_W] && (c_q < hwm_q) &&
                             (rs_top_q[LABEL_W-1:0] != cur_lab_q);
          nb_v_q[NB_LEFT] <= cur_v_q && left_v_q && (left_lab_q != cur_lab_q);
          nb_v_q[NB_TOP_LEFT] <= cur_v_q && diag_q && tl_v_q &&
                                 (tl_lab_q != cur_lab_q);
          nb_v_q[NB_TOP_RIGHT] <= cur_v_q && diag_q && rs_tr_q[LABEL_W] &&
                                  (cp1 < eff_cols) && (cp1 < hwm_q) &&
                                  (rs_tr_q[LABEL_W-1:0] != cur_lab_q);
          nb_lab_q[NB_TOP]       <= rs_top_q[LABEL_W-1:0];
          nb_lab_q[NB_LEFT]      <= left_lab_q;
          nb_lab_q[NB_TOP_LEFT]  <= tl_lab_q;
          nb_lab_q[NB_TOP_RIGHT] <= rs_tr_q[LABEL_W-1:0];
          if (cp1 > hwm_q) begin
            hwm_q <= cp1;
          end
          if (cp1 >= eff_cols) begin
            col_q    <= '0;
            left_v_q <= 1'b0;
            tl_v_q   <= 1'b0;
          end else begin
            col_q      <= cp1;
            left_v_q   <= cur_v_q;
            left_lab_q <= cur_lab_q;
            tl_v_q     <= rs_top_q[LABEL_W] && (c_q < hwm_q);
            tl_lab_q   <= rs_top_q[LABEL_W-1:0];
          end
          state_q <= S_NB;
        end

        S_NB: begin
          if (nb_v_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            key_lo_q <= (cur_lab_q < nb_lab) ? cur_lab_q : nb_lab;
            key_hi_q <= (cur_lab_q < nb_lab) ? nb_lab : cur_lab_q;
            nb_v_q[nb_sel] <= 1'b0;
            bs_lo_q <= '0;
            bs_hi_q <= stored_q;
            state_q <= S_SRCH;
          end
        end

        S_SRCH: begin
          if (bs_lo_q < bs_hi_q) begin
            state_q <= S_CMP;
          end else begin
            state_q <= S_MATCH;
          end
        end

        S_CMP: begin
          if (e_less) begin
            bs_lo_q <= mid + PCW'(1);
          end else begin
            bs_hi_q <= mid;
          end
          state_q <= S_SRCH;
        end

        S_MATCH: begin
          if (bs_lo_q < stored_q && e_eq) begin
            state_q <= S_NB;
          end else if (full) begin
            ovf_q   <= 1'b1;
            state_q <= S_NB;
          end else begin
            sh_q    <= stored_q;
            state_q <= S_SHRD;
          end
        end

        S_SHRD: begin
          if (sh_q == bs_lo_q) begin
            stored_q <= stored_q + PCW'(1);
            state_q  <= S_NB;
          end else begin
            state_q <= S_SHWR;
          end
        end

        S_SHWR: begin
          sh_q    <= sh_q - PCW'(1);
          state_q <= S_SHRD;
        end

        S_FETCH: begin
          if (out_free) begin
            table_overflow_o <= ovf_q;
            if (fetch_q < stored_q) begin
              lower_label_o  <= e_lo;
              higher_label_o <= e_hi;
              border_count_o <= e_cnt;
              pair_valid_o   <= 1'b1;
              last_pair_o    <= (fetch_q + PCW'(1) == stored_q);
              fetch_q        <= fetch_q + PCW'(1);
            end else begin
              lower_label_o  <= '0;
              higher_label_o <= '0;
              border_count_o <= '0;
              pair_valid_o   <= 1'b0;
              last_pair_o    <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the region adjacency counter unit: a directed table
// of transfers, a sequential-label run that fills the pair table to overflow,
// then random raster traffic over several row lengths and diagonal settings.
// Fetch results are checked against an in-bench pair table model or typed rows.
// ----------------------------------------------------------------------------
module tb;
  import rac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 60000; // cycles with no transfer
  localparam int unsigned SETTLE_CYCLES  = 3000;  // idle wait after each drain
  localparam int unsigned HOLD_CYCLES    = 2500;  // long receiver stall

  typedef struct {
    logic signed [LABEL_W-1:0] lower;
    logic signed [LABEL_W-1:0] higher;
    logic [COUNT_W-1:0]        count;
    logic                      pvalid;
    logic                      last;
    logic                      ovf;
  } pair_result_t;

  typedef struct {
    opcode_e                   op;
    logic signed [LABEL_W-1:0] label;
    logic                      is_null;
    bit                        typed;  // expected result written out below
    pair_result_t              res;
  } stim_row_t;

  // DUT ports
  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic                      cfg_index_i = 1'b0;
  logic [COLS_W-1:0]         cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                opcode_i = OP_NONE;
  logic signed [LABEL_W-1:0] pixel_label_i = '0;
  logic                      pixel_is_null_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [LABEL_W-1:0] lower_label_o;
  logic signed [LABEL_W-1:0] higher_label_o;
  logic [COUNT_W-1:0]        border_count_o;
  logic                      pair_valid_o;
  logic                      last_pair_o;
  logic                      table_overflow_o;

  region_adjacency_counter_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Adjacency model: previous row, left / top-left cells, sorted pair table.
  // --------------------------------------------------------------------------
  bit                        prev_row_valid [RAC_MAX_COLUMNS];
  logic signed [LABEL_W-1:0] prev_row_label [RAC_MAX_COLUMNS];
  bit                        left_valid, tl_valid;
  logic signed [LABEL_W-1:0] left_label, tl_label;
  int unsigned               col_pos;
  logic [COLS_W-1:0]         row_len_reg = COLS_RESET;
  bit                        diag_reg;
  logic signed [LABEL_W-1:0] tab_lo [$];
  logic signed [LABEL_W-1:0] tab_hi [$];
  logic [COUNT_W-1:0]        tab_cnt [$];
  int unsigned               fetch_pos;
  bit                        dropped_pair;

  pair_result_t pending_pairs [$];  // fetch results still to come out
  int           error_count;
  bit           hold_request;      // asks the receiver for the long stall

  function automatic void restart_raster();
    foreach (prev_row_valid[i]) begin
      prev_row_valid[i] = 1'b0;
      prev_row_label[i] = '0;
    end
    left_valid = 1'b0;
    tl_valid   = 1'b0;
    left_label = '0;
    tl_label   = '0;
    col_pos    = 0;
  endfunction

  function automatic void empty_table();
    tab_lo.delete();
    tab_hi.delete();
    tab_cnt.delete();
    fetch_pos    = 0;
    dropped_pair = 1'b0;
  endfunction

  function automatic int unsigned row_length();
    if (row_len_reg == 0) return 1;
    if (row_len_reg > RAC_MAX_COLUMNS) return RAC_MAX_COLUMNS;
    return row_len_reg;
  endfunction

  function automatic void count_contact(logic signed [LABEL_W-1:0] cur, bit nb_valid,
                                        logic signed [LABEL_W-1:0] nb);
    logic signed [LABEL_W-1:0] lo, hi;
    int unsigned pos;
    if (!nb_valid || nb == cur) return;
    lo = (cur < nb) ? cur : nb;
    hi = (cur < nb) ? nb : cur;
    pos = 0;
    while (pos < tab_lo.size() &&
           (tab_lo[pos] < lo || (tab_lo[pos] == lo && tab_hi[pos] < hi)))
      pos++;
    if (pos < tab_lo.size() && tab_lo[pos] == lo && tab_hi[pos] == hi) begin
      if (tab_cnt[pos] != '1) tab_cnt[pos]++;
      return;
    end
    if (tab_lo.size() >= RAC_MAX_PAIRS) begin
      dropped_pair = 1'b1;
      return;
    end
    tab_lo.insert(pos, lo);
    tab_hi.insert(pos, hi);
    tab_cnt.insert(pos, 1);
  endfunction

  // Applies one accepted item; returns 1 with the fetch result when there is one.
  function automatic bit adjacency_step(opcode_e op, logic signed [LABEL_W-1:0] label,
                                        logic is_null, output pair_result_t res);
    int unsigned cols, c;
    bit top_v, tr_v;
    logic signed [LABEL_W-1:0] top_l, tr_l;
    res = '{default: '0};
    case (op)
      OP_PIXEL: begin
        cols = row_length();
        if (col_pos >= cols) begin
          col_pos = 0;
          left_valid = 1'b0;
          tl_valid = 1'b0;
        end
        c = col_pos;
        top_v = prev_row_valid[c];
        top_l = prev_row_label[c];
        tr_v  = (c + 1 < cols) ? prev_row_valid[c+1] : 1'b0;
        tr_l  = (c + 1 < cols) ? prev_row_label[c+1] : '0;
        if (!is_null) begin
          count_contact(label, top_v, top_l);
          count_contact(label, left_valid, left_label);
          if (diag_reg) begin
            count_contact(label, tl_valid, tl_label);
            count_contact(label, tr_v, tr_l);
          end
        end
        prev_row_valid[c] = !is_null;
        prev_row_label[c] = is_null ? '0 : label;
        tl_valid   = top_v;
        tl_label   = top_l;
        left_valid = !is_null;
        left_label = is_null ? '0 : label;
        col_pos    = c + 1;
        if (col_pos >= cols) begin
          col_pos = 0;
          left_valid = 1'b0;
          tl_valid = 1'b0;
        end
        return 1'b0;
      end
      OP_CLEAR: begin
        restart_raster();
        empty_table();
        return 1'b0;
      end
      OP_FETCH: begin
        if (fetch_pos < tab_lo.size()) begin
          res.lower  = tab_lo[fetch_pos];
          res.higher = tab_hi[fetch_pos];
          res.count  = tab_cnt[fetch_pos];
          res.pvalid = 1'b1;
          res.last   = (fetch_pos + 1 == tab_lo.size());
          fetch_pos++;
        end
        res.ovf = dropped_pair;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side: bursts of transfers with random gaps, driven on falling edges.
  // --------------------------------------------------------------------------
  int  burst_left;
  bit  gaps_on = 1'b1;

  task automatic send_item(opcode_e op, logic signed [LABEL_W-1:0] label, logic is_null,
                           bit typed = 1'b0, pair_result_t typed_res = '{default: '0});
    pair_result_t res;
    bit           has_res;
    if (gaps_on && burst_left == 0) begin
      if (in_valid_i) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    if (in_valid_i) @(negedge clk_i);
    in_valid_i      = 1'b1;
    opcode_i        = op;
    pixel_label_i   = label;
    pixel_is_null_i = is_null;
    do @(posedge clk_i); while (!in_ready_o);
    // transfer taken at this edge
    has_res = adjacency_step(op, label, is_null, res);
    if (has_res) pending_pairs.push_back(typed ? typed_res : res);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain_and_settle();
    if (in_valid_i) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    while (pending_pairs.size() != 0) @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_index_e idx, logic [COLS_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_COLUMNS) row_len_reg = val;
    else diag_reg = val[0];
  endtask

  function automatic logic signed [LABEL_W-1:0] pick_label();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $signed($urandom_range(0, 11)) - 5;
    if (r < 80) return 32'sh8000_0000;
    if (r < 85) return 32'sh7fff_ffff;
    return $urandom();
  endfunction

  task automatic random_items(int unsigned n);
    int unsigned r;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70)      send_item(OP_PIXEL, pick_label(), $urandom_range(0, 99) < 15);
      else if (r < 93) send_item(OP_FETCH, $urandom(), 1'($urandom_range(0, 1)));
      else if (r < 96) send_item(OP_CLEAR, $urandom(), 1'($urandom_range(0, 1)));
      else             send_item(OP_NONE, $urandom(), 1'($urandom_range(0, 1)));
    end
  endtask

  // Directed table: part of a first row, with the obvious fetches written out.
  localparam pair_result_t NONE_LEFT = '{default: '0};
  stim_row_t directed [] = '{
    '{OP_FETCH, 32'sd0,           1'b0, 1'b1, NONE_LEFT},
    '{OP_PIXEL, 32'sd5,           1'b0, 1'b0, NONE_LEFT},
    '{OP_PIXEL, 32'sh8000_0000,   1'b0, 1'b0, NONE_LEFT},
    '{OP_PIXEL, 32'sh7fff_ffff,   1'b1, 1'b0, NONE_LEFT},  // null carries a label
    '{OP_PIXEL, 32'sd7,           1'b0, 1'b0, NONE_LEFT},
    '{OP_PIXEL, 32'sd9,           1'b0, 1'b0, NONE_LEFT},
    '{OP_PIXEL, 32'sh7fff_ffff,   1'b0, 1'b0, NONE_LEFT},
    '{OP_PIXEL, -32'sd1,          1'b0, 1'b0, NONE_LEFT},
    '{OP_PIXEL, -32'sd1,          1'b0, 1'b0, NONE_LEFT},  // same label: no pair
    '{OP_NONE,  32'sd3,           1'b0, 1'b0, NONE_LEFT},
    '{OP_FETCH, 32'sd0,           1'b0, 1'b1,
      '{32'sh8000_0000, 32'sd5, 32'd1, 1'b1, 1'b0, 1'b0}},
    '{OP_FETCH, 32'sd0,           1'b0, 1'b0, NONE_LEFT},
    '{OP_FETCH, 32'sd0,           1'b0, 1'b0, NONE_LEFT},
    '{OP_FETCH, 32'sd0,           1'b0, 1'b0, NONE_LEFT},
    '{OP_FETCH, 32'sd0,           1'b0, 1'b1, NONE_LEFT},
    '{OP_CLEAR, 32'sd0,           1'b0, 1'b0, NONE_LEFT},
    '{OP_FETCH, 32'sd0,           1'b0, 1'b1, NONE_LEFT}
  };

  // Row length and diagonal mode per random phase, extremes included.
  int unsigned phase_cols [8] = '{3, 1, 0, 8191, 5, 4096, 2, 7};
  bit          phase_diag [8] = '{0, 1, 1, 0, 1, 1, 1, 0};

  initial begin
    restart_raster();
    empty_table();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i])
      send_item(directed[i].op, directed[i].label, directed[i].is_null,
                directed[i].typed, directed[i].res);
    drain_and_settle();

    // Table fill: one column, labels ascending, so each new pair lands at the
    // top of the table; the last few are dropped and raise the overflow flag.
    write_reg(REG_COLUMNS, COLS_W'(1));
    write_reg(REG_DIAGONAL, '0);
    diag_reg = 1'b0;
    gaps_on = 1'b0;
    send_item(OP_CLEAR, '0, 1'b0);
    for (int i = 0; i < RAC_MAX_PAIRS + 6; i++) send_item(OP_PIXEL, i, 1'b0);
    send_item(OP_PIXEL, 32'sd3, 1'b0);  // another new pair while full
    for (int i = 0; i < 6; i++) send_item(OP_FETCH, '0, 1'b0);
    send_item(OP_CLEAR, '0, 1'b0);
    send_item(OP_FETCH, '0, 1'b0);
    gaps_on = 1'b1;
    drain_and_settle();

    hold_request = 1'b1;  // first random phase runs into a receiver stall
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_COLUMNS, COLS_W'(phase_cols[p]));
      write_reg(REG_DIAGONAL, COLS_W'(phase_diag[p]));
      gaps_on = (p % 3 != 2);
      send_item(OP_CLEAR, '0, 1'b0);
      random_items(p == 3 ? 40 : 85);
      drain_and_settle();
    end

    repeat (50) @(negedge clk_i);
    if (error_count == 0) $display("region_adjacency_counter_unit: match");
    else $display("region_adjacency_counter_unit: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: stall pattern chosen anew for each stretch, plus one long
  // hold-off that backs the fetches up into the input.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      mode = $urandom_range(0, 3);
      repeat (64) begin
        @(negedge clk_i);
        case (mode)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = $urandom_range(0, 1);
          2:       out_ready_i = ($urandom_range(0, 3) == 0);
          default: out_ready_i = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Result check, sampled on the rising edge.
  always @(posedge clk_i) begin
    pair_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pairs.size() == 0) begin
        $error("fetch result with nothing expected");
        error_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (lower_label_o !== want.lower) begin
          $error("lower_label exp %0d got %0d", want.lower, lower_label_o);
          error_count++;
        end
        if (higher_label_o !== want.higher) begin
          $error("higher_label exp %0d got %0d", want.higher, higher_label_o);
          error_count++;
        end
        if (border_count_o !== want.count) begin
          $error("border_count exp %0d got %0d", want.count, border_count_o);
          error_count++;
        end
        if (pair_valid_o !== want.pvalid) begin
          $error("pair_valid exp %0b got %0b", want.pvalid, pair_valid_o);
          error_count++;
        end
        if (last_pair_o !== want.last) begin
          $error("last_pair exp %0b got %0b", want.last, last_pair_o);
          error_count++;
        end
        if (table_overflow_o !== want.ovf) begin
          $error("table_overflow exp %0b got %0b", want.ovf, table_overflow_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: only counts while something is offered or owed.
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (!in_valid_i && pending_pairs.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("region_adjacency_counter_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
